// File: rtl/assert_macros.svh
// Assertion macros for the core, the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on clk, masked during reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on clk, masked during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/mtr_pkg.sv
// Package: constants, types and helper functions of the MT19937 ranged source.
package mtr_pkg;

  localparam int unsigned MtN   = 624;
  localparam int unsigned MtM   = 397;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned DivCntW = 6;

  localparam logic [31:0] MT_MATRIX    = 32'h9908b0df;
  localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c5680;
  localparam logic [31:0] MT_TEMPER_C  = 32'hefc60000;
  localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
  localparam logic [31:0] SEED_RESET   = 32'd5489;

  // Command codes
  localparam logic [1:0] CMD_RAW32 = 2'd0;
  localparam logic [1:0] CMD_RAW64 = 2'd1;
  localparam logic [1:0] CMD_RANGE = 2'd2;
  localparam logic [1:0] CMD_COIN  = 2'd3;

  // Size codes
  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;
  localparam logic [1:0] SZ_64 = 2'd3;

  // Register byte addresses
  localparam logic [2:0] REG_SEED = 3'd0;

  typedef enum logic [3:0] {
    ST_INIT_SEED,
    ST_INIT_MUL,
    ST_INIT_ADD,
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_RD_K,
    ST_RD_K1,
    ST_RD_KM,
    ST_UPD,
    ST_DIV0,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    RES_DRAW,
    RES_COIN,
    RES_BAD,
    RES_LO,
    RES_SUM
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     chk;
    logic     dec;
    logic     fill_seed;
    logic     fill_mul;
    logic     fill_add;
    logic     rd_k;
    logic     rd_k1;
    logic     rd_km;
    logic     upd;
    logic     div_init;
    logic     div_step;
    logic     out_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] size;
    logic       bad;
    logic       eq;
    logic       full;
    logic       fill_last;
    logic       div_last;
  } stat_t;

  // Mask of the chosen width
  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    logic [63:0] m;
    begin
      case (sz)
        SZ_8:    m = 64'h0000_0000_0000_00ff;
        SZ_16:   m = 64'h0000_0000_0000_ffff;
        SZ_32:   m = 64'h0000_0000_ffff_ffff;
        default: m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
    end
  endfunction

  // Sign bit of the chosen width
  function automatic logic [63:0] size_msb(input logic [1:0] sz);
    logic [63:0] m;
    begin
      case (sz)
        SZ_8:    m = 64'h0000_0000_0000_0080;
        SZ_16:   m = 64'h0000_0000_0000_8000;
        SZ_32:   m = 64'h0000_0000_8000_0000;
        default: m = 64'h8000_0000_0000_0000;
      endcase
      return m;
    end
  endfunction

  // MT19937 output tempering
  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    begin
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & MT_TEMPER_B);
      y = y ^ ((y << 15) & MT_TEMPER_C);
      y = y ^ (y >> 18);
      return y;
    end
  endfunction

endpackage

// File: rtl/mt19937_ranged_random_source_core.sv
// MT19937 ranged draw: 32-bit tempered words, 64-bit pairs, ranged values and coin flips.
// Steps per request: capture, bound check, decide; per store word, reads at k, k+1 and k+M
// and an update; non-full ranged draws then run a bit-serial 64-bit remainder; last the result loads.
// One item in flight; the next beat is taken the cycle after the result loads;
// three store reads per word and the remainder steps set the pace.
// After reset or a seed write the store refills with the input stalled.
// Reset is synchronous and active low; the seed register resets to 5489.
module mt19937_ranged_random_source_core
  import mtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_size_sel,
  input  logic        in_is_signed,
  input  logic [63:0] in_low_bound,
  input  logic [63:0] in_high_bound,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  output logic        out_bad_range,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "assert_macros.svh"

  logic [31:0] seed_r;
  logic        seed_wr;
  cmd_t        cmd;
  stat_t       stat;

  // Register port
  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && (paddr[2] == REG_SEED[2]);
  assign prdata  = (paddr[2] == REG_SEED[2]) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (seed_wr) begin
      seed_r <= pwdata;
    end
  end

  mtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .seed_wr   (seed_wr),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  mtr_datapath u_dp (
    .clk           (clk),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .seed          (seed_r),
    .in_cmd        (in_cmd),
    .in_size_sel   (in_size_sel),
    .in_is_signed  (in_is_signed),
    .in_low_bound  (in_low_bound),
    .in_high_bound (in_high_bound),
    .out_value     (out_value),
    .out_bad_range (out_bad_range)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat did not busy the block")
  `ASSERT_NEXT(a_refill_on_seed, seed_wr, in_stall, "seed write did not start a refill")
  `ASSERT_NOW(a_bad_zero, out_valid && out_bad_range, out_value == 64'd0, "bad range with nonzero value")

endmodule

// File: rtl/mtr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mtr_datapath.sv
// Datapath: state store, tempering, bound checks, serial modulo and result register.
module mtr_datapath
  import mtr_pkg::*;
(
  input  logic        clk,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [31:0] seed,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_size_sel,
  input  logic        in_is_signed,
  input  logic [63:0] in_low_bound,
  input  logic [63:0] in_high_bound,
  output logic [63:0] out_value,
  output logic        out_bad_range
);

  logic [1:0]        cmd_r, size_r;
  logic              sgn_r;
  logic [63:0]       lo_r, hi_r, mask_r, diff_r, dvs_r, draw_r, rem_r;
  logic              bad_r, eq_r;
  logic [IdxW-1:0]   k_r, fi_r;
  logic [31:0]       v_r, prod_r;
  logic              xu_r;
  logic [30:0]       xl_r;
  logic [DivCntW-1:0] div_cnt_r;
  logic [63:0]       value_r;
  logic              bad_out_r;

  logic [IdxW-1:0]   k1, km;
  logic [IdxW:0]     kp;
  logic [31:0]       xa, xnew, fill_v, rdata;
  logic [63:0]       flip, mask_in;
  logic [64:0]       trial;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata;

  // Neighbor indexes in the circular store
  always_comb begin
    kp = {1'b0, k_r} + (IdxW+1)'(MtM);
    km = (kp >= (IdxW+1)'(MtN)) ? IdxW'(kp - (IdxW+1)'(MtN)) : kp[IdxW-1:0];
    k1 = (k_r == IdxW'(MtN - 1)) ? '0 : k_r + 1'b1;
  end

  // Twist and fill arithmetic
  always_comb begin
    xa     = {1'b0, xu_r, xl_r[30:1]} ^ (xl_r[0] ? MT_MATRIX : 32'd0);
    xnew   = rdata ^ xa;
    fill_v = prod_r + {{(32-IdxW){1'b0}}, fi_r};
    flip   = sgn_r ? size_msb(size_r) : 64'd0;
    mask_in = size_mask(in_size_sel);
    trial  = {rem_r, draw_r[63]};
  end

  // Store port muxing
  always_comb begin
    ram_we    = cmd_i.fill_seed | cmd_i.fill_add | cmd_i.upd;
    ram_waddr = cmd_i.fill_seed ? '0 : (cmd_i.fill_add ? fi_r : k_r);
    ram_wdata = cmd_i.fill_seed ? seed : (cmd_i.fill_add ? fill_v : xnew);
    if (cmd_i.rd_k1) begin
      ram_raddr = k1;
    end else if (cmd_i.rd_km) begin
      ram_raddr = km;
    end else begin
      ram_raddr = k_r;
    end
  end

  mtr_ram #(.Width(32), .Depth(MtN)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Request capture and bound checks
  always_ff @(posedge clk) begin
    if (cmd_i.load_in) begin
      cmd_r  <= in_cmd;
      size_r <= in_size_sel;
      sgn_r  <= in_is_signed;
      mask_r <= mask_in;
      lo_r   <= in_low_bound & mask_in;
      hi_r   <= in_high_bound & mask_in;
    end
    if (cmd_i.chk) begin
      bad_r  <= (lo_r ^ flip) > (hi_r ^ flip);
      eq_r   <= lo_r == hi_r;
      diff_r <= (hi_r - lo_r) & mask_r;
    end
    if (cmd_i.dec) begin
      dvs_r <= diff_r + 64'd1;
    end
  end

  // Store initialization from the seed, and the store index advance on each update
  always_ff @(posedge clk) begin
    if (cmd_i.fill_seed) begin
      v_r  <= seed;
      fi_r <= IdxW'(1);
      k_r  <= '0;
    end else if (cmd_i.fill_add) begin
      v_r  <= fill_v;
      fi_r <= fi_r + 1'b1;
    end else if (cmd_i.upd) begin
      k_r  <= k1;
    end
    if (cmd_i.fill_mul) begin
      prod_r <= MT_INIT_MULT * (v_r ^ (v_r >> 30));
    end
  end

  // Word generation and serial remainder
  always_ff @(posedge clk) begin
    if (cmd_i.rd_k1) begin
      xu_r <= rdata[31];
    end
    if (cmd_i.rd_km) begin
      xl_r <= rdata[30:0];
    end
    if (cmd_i.load_in) begin
      draw_r <= '0;
    end else if (cmd_i.upd) begin
      draw_r <= {draw_r[31:0], temper(xnew)};
    end else if (cmd_i.div_step) begin
      draw_r <= {draw_r[62:0], 1'b0};
    end
    if (cmd_i.div_init) begin
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd_i.div_step) begin
      rem_r     <= (trial >= {1'b0, dvs_r}) ? 64'(trial - {1'b0, dvs_r}) : trial[63:0];
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      bad_out_r <= 1'b0;
      case (cmd_i.res_sel)
        RES_DRAW: value_r <= draw_r;
        RES_COIN: value_r <= {63'd0, ~draw_r[0]};
        RES_BAD: begin
          value_r   <= '0;
          bad_out_r <= 1'b1;
        end
        RES_LO:   value_r <= lo_r;
        default:  value_r <= (lo_r + rem_r) & mask_r;
      endcase
    end
  end

  assign out_value     = value_r;
  assign out_bad_range = bad_out_r;

  always_comb begin
    stat_o.cmd       = cmd_r;
    stat_o.size      = size_r;
    stat_o.bad       = bad_r;
    stat_o.eq        = eq_r;
    stat_o.full      = (diff_r == mask_r) && (size_r[1] == 1'b1);
    stat_o.fill_last = fi_r == IdxW'(MtN - 1);
    stat_o.div_last  = div_cnt_r == '1;
  end

endmodule

// File: rtl/mtr_ctrl.sv
// Controller: sequences store fill, word draws, modulo steps and the result beat.
module mtr_ctrl
  import mtr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  seed_wr,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_t state_r, state_nxt;
  logic   need2_r, need2_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT_SEED;
      need2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      need2_r     <= need2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    need2_nxt     = need2_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd_o         = '0;
    cmd_o.res_sel = RES_DRAW;
    unique case (state_r)
      ST_INIT_SEED: begin
        cmd_o.fill_seed = 1'b1;
        state_nxt = ST_INIT_MUL;
      end
      ST_INIT_MUL: begin
        cmd_o.fill_mul = 1'b1;
        state_nxt = ST_INIT_ADD;
      end
      ST_INIT_ADD: begin
        cmd_o.fill_add = 1'b1;
        state_nxt = stat_i.fill_last ? ST_IDLE : ST_INIT_MUL;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.load_in = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.chk = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.dec = 1'b1;
        if (stat_i.cmd != CMD_RANGE) begin
          need2_nxt = stat_i.cmd == CMD_RAW64;
          state_nxt = ST_RD_K;
        end else if (stat_i.bad || stat_i.eq) begin
          state_nxt = ST_OUT;
        end else begin
          need2_nxt = stat_i.full ? (stat_i.size == SZ_64) : stat_i.size[1];
          state_nxt = ST_RD_K;
        end
      end
      ST_RD_K: begin
        cmd_o.rd_k = 1'b1;
        state_nxt = ST_RD_K1;
      end
      ST_RD_K1: begin
        cmd_o.rd_k1 = 1'b1;
        state_nxt = ST_RD_KM;
      end
      ST_RD_KM: begin
        cmd_o.rd_km = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        if (need2_r) begin
          need2_nxt = 1'b0;
          state_nxt = ST_RD_K;
        end else if (stat_i.cmd == CMD_RANGE && !stat_i.full) begin
          state_nxt = ST_DIV0;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV0: begin
        cmd_o.div_init = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat_i.cmd == CMD_COIN) begin
          cmd_o.res_sel = RES_COIN;
        end else if (stat_i.cmd != CMD_RANGE) begin
          cmd_o.res_sel = RES_DRAW;
        end else if (stat_i.bad) begin
          cmd_o.res_sel = RES_BAD;
        end else if (stat_i.eq) begin
          cmd_o.res_sel = RES_LO;
        end else if (stat_i.full) begin
          cmd_o.res_sel = RES_DRAW;
        end else begin
          cmd_o.res_sel = RES_SUM;
        end
        if (!out_valid_r || !out_stall) begin
          cmd_o.out_load = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT_SEED;
    endcase
    // A seed write restarts the store fill
    if (seed_wr) begin
      state_nxt     = ST_INIT_SEED;
      cmd_o.load_in = 1'b0;
    end
  end

  // Hold off input beats while busy or while the seed is being rewritten
  assign in_stall  = (state_r != ST_IDLE) || seed_wr;
  assign out_valid = out_valid_r;

endmodule

// File: tb/mt19937_ranged_random_source_core_tb.sv
// Testbench for the MT19937 ranged random source: directed table, random draws, seed changes.
`timescale 1ns / 100ps

module mt19937_ranged_random_source_core_tb;
  import mtr_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned RandPerSeed = 100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [1:0]  in_size_sel;
  logic        in_is_signed;
  logic [63:0] in_low_bound;
  logic [63:0] in_high_bound;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_value;
  logic        out_bad_range;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mt19937_ranged_random_source_core u_dut (.*);

  // One draw request and its expected result
  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  size;
    logic        sgn;
    logic [63:0] lo;
    logic [63:0] hi;
    bit          typed;
    logic [63:0] val;
    logic        bad;
  } draw_row_t;

  typedef struct {
    logic [63:0] val;
    logic        bad;
  } draw_res_t;

  // Generator mirror
  logic [31:0] mt_words [MtN];
  int unsigned mt_pos;
  draw_res_t   pending_draws [$];

  int unsigned errors;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned seeds_used;
  int unsigned idle_cycles;
  bit          out_quiet;

  task automatic mt_seed(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    mt_words[0] = v;
    for (int i = 1; i < MtN; i++) begin
      v = MT_INIT_MULT * (v ^ (v >> 30)) + 32'(i);
      mt_words[i] = v;
    end
    mt_pos = 0;
  endtask

  function automatic logic [31:0] mt_word();
    int unsigned k1, km;
    logic [31:0] x, xa, y;
    k1 = (mt_pos + 1) % MtN;
    km = (mt_pos + MtM) % MtN;
    x  = (mt_words[mt_pos] & 32'h8000_0000) | (mt_words[k1] & 32'h7fff_ffff);
    xa = x >> 1;
    if (x[0]) xa ^= MT_MATRIX;
    x = mt_words[km] ^ xa;
    mt_words[mt_pos] = x;
    mt_pos = k1;
    y = x ^ (x >> 11);
    y ^= (y << 7) & MT_TEMPER_B;
    y ^= (y << 15) & MT_TEMPER_C;
    y ^= y >> 18;
    return y;
  endfunction

  function automatic logic [63:0] mt_pair();
    logic [31:0] hi_w;
    hi_w = mt_word();
    return {hi_w, mt_word()};
  endfunction

  function automatic logic [63:0] width_mask(input logic [1:0] sz);
    case (sz)
      SZ_8:    return 64'hff;
      SZ_16:   return 64'hffff;
      SZ_32:   return 64'hffff_ffff;
      default: return '1;
    endcase
  endfunction

  function automatic logic [63:0] sign_flip(input logic [1:0] sz, input logic sgn);
    return sgn ? (width_mask(sz) ^ (width_mask(sz) >> 1)) : 64'h0;
  endfunction

  // Advance the mirror by one request and return what the block should send
  function automatic draw_res_t draw_predict(input draw_row_t r);
    draw_res_t   res;
    logic [63:0] m, lo, hi, fl, span, d;
    logic [31:0] w;
    res = '{val: '0, bad: 1'b0};
    case (r.cmd)
      CMD_RAW32: res.val = {32'h0, mt_word()};
      CMD_RAW64: res.val = mt_pair();
      CMD_COIN: begin
        w       = mt_word();
        res.val = {63'h0, ~w[0]};
      end
      default: begin
        m  = width_mask(r.size);
        lo = r.lo & m;
        hi = r.hi & m;
        fl = sign_flip(r.size, r.sgn);
        if ((lo ^ fl) > (hi ^ fl)) begin
          res.bad = 1'b1;
        end else if (lo == hi) begin
          res.val = lo;
        end else begin
          span = (hi - lo) & m;
          if (span == m && r.size >= SZ_32) begin
            res.val = (r.size == SZ_64) ? mt_pair() : {32'h0, mt_word()};
          end else begin
            d = (r.size >= SZ_32) ? mt_pair() : {32'h0, mt_word()};
            res.val = (lo + d % (span + 64'd1)) & m;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stall, compare every beat
  always @(posedge clk) begin
    draw_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (pending_draws.size() == 0) begin
          report_mismatch("unexpected beat", out_value, 64'h0);
        end else begin
          want = pending_draws.pop_front();
          if (out_value !== want.val) report_mismatch("value", out_value, want.val);
          if (out_bad_range !== want.bad)
            report_mismatch("bad_range", {63'h0, out_bad_range}, {63'h0, want.bad});
        end
      end
      if ($urandom_range(0, 199) == 0) out_quiet = ~out_quiet;
      out_stall <= out_quiet ? 1'b0 : (gap_len() != 0);
    end
  end

  // Watchdog on cycles with no accepted beat on either side and no register access
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Send one request; the first edge with valid high and no stall takes it
  task automatic send_draw(input draw_row_t r);
    draw_res_t res;
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= r.cmd;
    in_size_sel   <= r.size;
    in_is_signed  <= r.sgn;
    in_low_bound  <= r.lo;
    in_high_bound <= r.hi;
    do @(posedge clk); while (in_stall);
    beats_in++;
    res = draw_predict(r);
    if (r.typed) begin
      res.val = r.val;
      res.bad = r.bad;
    end
    pending_draws.push_back(res);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Seed write over the register port, only with the block idle
  task automatic write_seed(input logic [31:0] s);
    drain_results();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_SEED;
    pwdata  <= s;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mt_seed(s);
    seeds_used++;
  endtask

  // Random bound: wide values, small values and edge patterns
  function automatic logic [63:0] rand_bound();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return {1'($urandom_range(0, 1)), 63'h0} | 64'($urandom_range(0, 3));
      3:       return 64'($urandom_range(0, 300));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic draw_row_t rand_draw();
    draw_row_t   r;
    logic [63:0] m, fl, t;
    r.cmd   = 2'($urandom_range(0, 3));
    r.size  = 2'($urandom_range(0, 3));
    r.sgn   = 1'($urandom_range(0, 1));
    r.lo    = rand_bound();
    r.hi    = rand_bound();
    r.typed = 1'b0;
    r.val   = '0;
    r.bad   = 1'b0;
    if (r.cmd != CMD_RANGE) r.cmd = $urandom_range(0, 1) ? CMD_RANGE : r.cmd;
    // Mostly well-ordered ranges so the draw path is exercised
    m  = width_mask(r.size);
    fl = sign_flip(r.size, r.sgn);
    if ($urandom_range(0, 3) != 0 && ((r.lo & m) ^ fl) > ((r.hi & m) ^ fl)) begin
      t    = r.lo;
      r.lo = r.hi;
      r.hi = t;
    end
    return r;
  endfunction

  draw_row_t opening_rows [] = '{
    // first outputs of the default seed
    '{CMD_RAW32, SZ_8,  1'b0, '0, '0, 1'b1, 64'h0000_0000_d091_bb5c, 1'b0},
    '{CMD_RAW64, SZ_64, 1'b1, '1, '1, 1'b1, 64'h22ae_9ef6_e7e1_faee, 1'b0},
    '{CMD_COIN,  SZ_16, 1'b1, '1, '0, 1'b0, '0, 1'b0},
    // inverted bounds
    '{CMD_RANGE, SZ_8,  1'b0, 64'h5, 64'h3, 1'b1, '0, 1'b1},
    '{CMD_RANGE, SZ_8,  1'b1, 64'h01, 64'hff, 1'b1, '0, 1'b1},
    '{CMD_RANGE, SZ_64, 1'b1, 64'h0, 64'h8000_0000_0000_0000, 1'b1, '0, 1'b1},
    '{CMD_RANGE, SZ_32, 1'b0, '1, 64'h0, 1'b1, '0, 1'b1},
    // equal bounds, junk above the width
    '{CMD_RANGE, SZ_8,  1'b0, 64'hffff_ffff_ffff_ff12, 64'h12, 1'b1, 64'h12, 1'b0},
    '{CMD_RANGE, SZ_16, 1'b1, 64'h8000, 64'hdead_8000, 1'b1, 64'h8000, 1'b0},
    '{CMD_RANGE, SZ_64, 1'b0, '1, '1, 1'b1, '1, 1'b0},
    // full ranges
    '{CMD_RANGE, SZ_32, 1'b0, 64'h0, 64'hffff_ffff, 1'b0, '0, 1'b0},
    '{CMD_RANGE, SZ_64, 1'b1, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 1'b0, '0, 1'b0},
    '{CMD_RANGE, SZ_8,  1'b1, 64'h80, 64'h7f, 1'b0, '0, 1'b0},
    '{CMD_RANGE, SZ_16, 1'b0, 64'h0, 64'hffff, 1'b0, '0, 1'b0},
    // ordinary ranges
    '{CMD_RANGE, SZ_8,  1'b1, 64'hf6, 64'h0a, 1'b0, '0, 1'b0},
    '{CMD_RANGE, SZ_16, 1'b0, 64'h10, 64'h1000, 1'b0, '0, 1'b0},
    '{CMD_RANGE, SZ_32, 1'b1, 64'hffff_ff00, 64'h100, 1'b0, '0, 1'b0},
    '{CMD_RANGE, SZ_64, 1'b0, 64'h1, 64'hffff_ffff_ffff_fffe, 1'b0, '0, 1'b0},
    '{CMD_RANGE, SZ_64, 1'b1, 64'hffff_ffff_ffff_fffd, 64'h3, 1'b0, '0, 1'b0},
    '{CMD_RANGE, SZ_32, 1'b0, 64'h0, 64'h7, 1'b0, '0, 1'b0},
    '{CMD_COIN,  SZ_8,  1'b0, '0, '0, 1'b0, '0, 1'b0}
  };

  logic [31:0] seed_list [] = '{32'h0, 32'hffff_ffff, 32'h1, 32'h0};

  initial begin
    errors     = 0;
    beats_in   = 0;
    beats_out  = 0;
    seeds_used = 1;
    idle_cycles = 0;
    out_quiet  = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_RAW32;
    in_size_sel   = SZ_8;
    in_is_signed  = 1'b0;
    in_low_bound  = '0;
    in_high_bound = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = REG_SEED;
    pwdata        = '0;
    seed_list[3]  = $urandom;
    mt_seed(SEED_RESET);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) send_draw(opening_rows[i]);
    repeat (RandPerSeed) send_draw(rand_draw());
    foreach (seed_list[s]) begin
      write_seed(seed_list[s]);
      repeat (RandPerSeed) send_draw(rand_draw());
    end

    drain_results();
    $display("%0d requests sent, %0d results checked, %0d seeds in use",
             beats_in, beats_out, seeds_used);
    $display("covered raw, coin, ranged draws at all widths, inverted and equal bounds");
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
